FILE: rtl/mandelbrot_escape_pixel_unit_defines.svh
// Assertion macros shared by the escape pixel unit RTL.
// Standalone header; each use names its clock and its reset.
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication
`define MEP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mep assertion failed");

// next-cycle implication
`define MEP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mep assertion failed");

`endif

FILE: rtl/mep_pkg.sv
// Shared types and constants for the escape pixel unit.
// No dependencies; imported by the interfaces and the top level.
package mep_pkg;

  localparam int COL_W   = 12;
  localparam int ROW_W   = 12;
  localparam int DIM_W   = 13;
  localparam int MIT_W   = 16;
  localparam int ADDR_W  = 24;
  localparam int SHADE_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 13'd480;
  localparam logic [MIT_W-1:0] RST_MAX_ITERATIONS = 16'd255;

  localparam int SHADE_SCALE = 255;

  // digit width of the shared serial multiplier
  localparam int DIGIT_W = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_RE,
    S_DIV_IM,
    S_SQ_RE,
    S_SQ_IM,
    S_TEST,
    S_MUL_RI,
    S_SHADE,
    S_DONE
  } state_t;

endpackage

FILE: rtl/mep_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on mep_pkg for the field widths.
interface mep_cfg_if import mep_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mep_coord_if.sv
// Pixel coordinate channel: one column and row per beat.
// Depends on mep_pkg for the field widths.
interface mep_coord_if import mep_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

FILE: rtl/mep_pixel_if.sv
// Result channel: pixel address, shade and out-of-range flag per beat.
// Depends on mep_pkg for the field widths.
interface mep_pixel_if import mep_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [SHADE_W-1:0] shade;
  logic               out_of_range;

  modport source (output valid, pixel_address, shade, out_of_range, input ready);
  modport sink   (input valid, pixel_address, shade, out_of_range, output ready);
endinterface

FILE: rtl/mandelbrot_escape_pixel_unit.sv
// Mandelbrot escape-time shader for one pixel per beat.
// Channels: cfg writes frame_width (0), frame_height (1), max_iterations (2);
// coord takes a column and row; pixel returns address, shade, out_of_range.
// One beat at a time: coord.ready is high only while the unit is idle. A beat
// outside the frame skips the arithmetic and goes straight to the finish.
// Otherwise the two point divisions run on the radix-2 divider, then the first
// squaring and each iteration run on the single serial multiplier, and on
// escape the shade division runs on the divider before the finish.
// The result sits in an output register; a new coordinate is taken while it
// waits, and the unit holds its next result until pixel.ready frees the slot.
// Reset (rst, synchronous) returns to idle, drops any pending result and
// loads 640 x 480 with 255 iterations. Configuration is taken every cycle
// and must only change while the unit is idle with no pending result.
// Depends on mep_pkg, the three mep_*_if interfaces and the defines header.
`include "mandelbrot_escape_pixel_unit_defines.svh"

module mandelbrot_escape_pixel_unit import mep_pkg::*; #(
  parameter int FRAC_BITS = 26,
  parameter int MAX_DIM   = 4096
) (
  input logic          clk,
  input logic          rst,
  mep_cfg_if.sink      cfg,
  mep_coord_if.sink    coord,
  mep_pixel_if.source  pixel
);

  localparam int MW  = FRAC_BITS + 3;              // operand magnitude bits
  localparam int VW  = FRAC_BITS + 4;              // signed z / c width
  localparam int PW  = FRAC_BITS + 6;              // product magnitude bits
  localparam int EW  = PW + 2;                     // update sum width
  localparam int ND  = (MW + DIGIT_W - 1) / DIGIT_W;
  localparam int BW  = ND * DIGIT_W;
  localparam int AW  = MW + BW;
  localparam int DCW = $clog2(ND);
  localparam int NW  = FRAC_BITS + 14;             // dividend bits
  localparam int SCW = $clog2(NW);
  localparam int RW  = MIT_W;                      // divisor / remainder bits

  localparam logic signed [VW-1:0] NEG_TWO = {3'b111, {(FRAC_BITS + 1){1'b0}}};
  localparam logic signed [VW-1:0] NEG_SEVEN_QUARTERS =
    {6'b111001, {(FRAC_BITS - 2){1'b0}}};
  localparam logic [PW:0] FOUR_FX = (PW + 1)'(4) << FRAC_BITS;

  function automatic logic [MW-1:0] fx_mag(input logic signed [VW-1:0] x);
    logic [VW-1:0] n;
    n = -x;
    return x[VW-1] ? n[MW-1:0] : x[MW-1:0];
  endfunction

  // configuration
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [MIT_W-1:0] max_iterations;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // control
  state_t state, state_next;
  logic   first;
  logic   out_valid;
  logic   out_load;
  logic [MIT_W-1:0] k;

  // pixel payload
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             oor_q;
  logic [SHADE_W-1:0] shade_q;
  logic             oor_in;
  logic [ADDR_W:0]  addr_full;

  // orbit
  logic signed [VW-1:0] re, im, cre, cim;
  logic [PW-1:0] rr, ii;

  // serial multiplier
  logic [AW-1:0]        acc, acc_step;
  logic [DCW-1:0]       dcnt, didx;
  logic [MW-1:0]        mul_a, mul_b;
  logic [BW-1:0]        b_pad;
  logic [DIGIT_W-1:0]   digit;
  logic [MW+DIGIT_W-1:0] partial;
  logic                 mul_neg, mul_last;
  logic [PW-1:0]        prod_mag;
  logic signed [PW:0]   prod_s;
  logic signed [EW-1:0] re_sum, im_sum;

  // radix-2 divider
  logic [NW-1:0]  nq, nq_step;
  logic [RW-1:0]  rem, rem_step, dvs;
  logic [RW:0]    trial, diff;
  logic           take, div_last;
  logic [SCW-1:0] scnt;
  logic signed [VW-1:0] c_from_q_re, c_from_q_im;

  // iteration test
  logic [MIT_W-1:0] k_inc, k_cont;
  logic             esc_big, escape, keep_going;

  assign w_eff = (frame_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width;
  assign h_eff = (frame_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height;
  assign oor_in = (DIM_W'(coord.column) >= w_eff) || (DIM_W'(coord.row) >= h_eff);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      max_iterations <= RST_MAX_ITERATIONS;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FRAME_WIDTH:    frame_width    <= cfg.data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg.data[DIM_W-1:0];
        CFG_MAX_ITERATIONS: max_iterations <= cfg.data[MIT_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier: one 16-bit digit of b per cycle, most significant first
  always_comb begin
    case (state)
      S_SQ_IM: begin
        mul_a   = fx_mag(im);
        mul_b   = fx_mag(im);
        mul_neg = 1'b0;
      end
      S_MUL_RI: begin
        mul_a   = fx_mag(re);
        mul_b   = fx_mag(im);
        mul_neg = re[VW-1] ^ im[VW-1];
      end
      default: begin
        mul_a   = fx_mag(re);
        mul_b   = fx_mag(re);
        mul_neg = 1'b0;
      end
    endcase
    b_pad    = BW'(mul_b);
    didx     = DCW'(ND - 1) - dcnt;
    digit    = b_pad[didx*DIGIT_W +: DIGIT_W];
    partial  = (MW + DIGIT_W)'(mul_a) * (MW + DIGIT_W)'(digit);
    acc_step = ((dcnt == '0) ? '0 : (acc << DIGIT_W)) + AW'(partial);
    mul_last = (dcnt == DCW'(ND - 1));
    prod_mag = acc_step[FRAC_BITS +: PW];
    prod_s   = mul_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
    re_sum   = $signed({1'b0, rr}) - $signed({1'b0, ii}) + EW'(cre);
    im_sum   = (EW'(prod_s) <<< 1) + EW'(cim);
  end

  // divider: one quotient bit per cycle
  always_comb begin
    trial       = {rem, nq[NW-1]};
    take        = (trial >= {1'b0, dvs});
    diff        = trial - {1'b0, dvs};
    rem_step    = take ? diff[RW-1:0] : trial[RW-1:0];
    nq_step     = {nq[NW-2:0], take};
    div_last    = (scnt == SCW'(NW - 1));
    c_from_q_re = NEG_TWO + $signed({2'b00, nq_step[FRAC_BITS+1:0]});
    c_from_q_im = NEG_SEVEN_QUARTERS + $signed({2'b00, nq_step[FRAC_BITS+1:0]});
  end

  always_comb begin
    k_inc      = k + MIT_W'(1);
    k_cont     = first ? k : k_inc;
    esc_big    = ((PW + 1)'(rr) + (PW + 1)'(ii)) > FOUR_FX;
    escape     = !first && esc_big;
    keep_going = (k_cont < max_iterations);
    addr_full  = (ADDR_W + 1)'(row_q) * (ADDR_W + 1)'(w_eff) + (ADDR_W + 1)'(col_q);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (coord.valid) state_next = oor_in ? S_DONE : S_DIV_RE;
      S_DIV_RE: if (div_last) state_next = S_DIV_IM;
      S_DIV_IM: if (div_last) state_next = S_SQ_RE;
      S_SQ_RE:  if (mul_last) state_next = S_SQ_IM;
      S_SQ_IM:  if (mul_last) state_next = S_TEST;
      S_TEST: begin
        if (escape) state_next = S_SHADE;
        else if (!keep_going) state_next = S_DONE;
        else state_next = S_MUL_RI;
      end
      S_MUL_RI: if (mul_last) state_next = S_SQ_RE;
      S_SHADE:  if (div_last) state_next = S_DONE;
      S_DONE:   if (!out_valid || pixel.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    coord.ready = (state == S_IDLE);
    out_load    = (state == S_DONE) && (!out_valid || pixel.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dcnt      <= '0;
      scnt      <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (pixel.ready) out_valid <= 1'b0;
      if (state == S_SQ_RE || state == S_SQ_IM || state == S_MUL_RI) begin
        dcnt <= mul_last ? '0 : dcnt + DCW'(1);
      end
      if (state == S_DIV_RE || state == S_DIV_IM || state == S_SHADE) begin
        scnt <= div_last ? '0 : scnt + SCW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (coord.valid) begin
          col_q   <= coord.column;
          row_q   <= coord.row;
          oor_q   <= oor_in;
          shade_q <= '0;
          k       <= '0;
          first   <= 1'b1;
          nq      <= {(COL_W + 2)'(coord.column) * (COL_W + 2)'(3),
                      {FRAC_BITS{1'b0}}};
          rem     <= '0;
          dvs     <= RW'(w_eff);
        end
      end
      S_DIV_RE: begin
        if (div_last) begin
          cre <= c_from_q_re;
          re  <= c_from_q_re;
          nq  <= {(ROW_W + 3)'(row_q) * (ROW_W + 3)'(7), {(FRAC_BITS - 1){1'b0}}};
          rem <= '0;
          dvs <= RW'(h_eff);
        end else begin
          nq  <= nq_step;
          rem <= rem_step;
        end
      end
      S_DIV_IM: begin
        if (div_last) begin
          cim <= c_from_q_im;
          im  <= c_from_q_im;
        end else begin
          nq  <= nq_step;
          rem <= rem_step;
        end
      end
      S_SQ_RE: begin
        acc <= acc_step;
        if (mul_last) rr <= prod_mag;
      end
      S_SQ_IM: begin
        acc <= acc_step;
        if (mul_last) ii <= prod_mag;
      end
      S_TEST: begin
        first <= 1'b0;
        if (escape) begin
          // shade = k * 255 / max_iterations, k below the limit here
          nq  <= NW'(ADDR_W'(k) * ADDR_W'(SHADE_SCALE));
          rem <= '0;
          dvs <= max_iterations;
        end else begin
          k <= k_cont;
        end
      end
      S_MUL_RI: begin
        acc <= acc_step;
        if (mul_last) begin
          re <= re_sum[VW-1:0];
          im <= im_sum[VW-1:0];
        end
      end
      S_SHADE: begin
        if (div_last) shade_q <= nq_step[SHADE_W-1:0];
        else begin
          nq  <= nq_step;
          rem <= rem_step;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      pixel.pixel_address <= addr_full[ADDR_W-1:0];
      pixel.shade         <= shade_q;
      pixel.out_of_range  <= oor_q;
    end
  end

  assign pixel.valid = out_valid;

  `MEP_ASSERT_NEXT(a_busy_after_beat, clk, rst, coord.valid && coord.ready, state != S_IDLE)
  `MEP_ASSERT_SAME(a_oor_dark, clk, rst, pixel.valid && pixel.out_of_range, pixel.shade == 8'd0)
  `MEP_ASSERT_SAME(a_iter_below_limit, clk, rst, state == S_MUL_RI, k < max_iterations)
  `MEP_ASSERT_SAME(a_shade_divisor, clk, rst, state == S_SHADE, dvs != '0)

endmodule

FILE: bench/mep_escape_checker.sv
// Scoreboard for the escape pixel unit: shadows the frame registers from the
// cfg channel, predicts one pixel beat per coordinate beat and compares.
// Depends on mep_pkg and the mep_cfg_if, mep_coord_if and mep_pixel_if interfaces.
module mep_escape_checker import mep_pkg::*; #(
  parameter int FRAC_BITS = 26,
  parameter int MAX_DIM   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  mep_cfg_if          cfg,
  mep_coord_if        coord,
  mep_pixel_if        pixel,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [SHADE_W-1:0] shade;
    logic               oor;
  } pixel_rec_t;

  pixel_rec_t expected_pixels[$];
  pixel_rec_t want;
  pixel_rec_t got;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [MIT_W-1:0] iter_limit;

  // exact product, then shift right by FRAC_BITS truncating toward zero
  function automatic longint fixed_mul(longint a, longint b);
    logic [127:0] prod;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  mag;
    logic         neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? 64'(-a) : 64'(a);
    ub   = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'd0, ua} * {64'd0, ub};
    mag  = prod[FRAC_BITS +: 64];
    mag[63] = 1'b0;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic pixel_rec_t shade_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    longint     w;
    longint     h;
    longint     mit;
    longint     one;
    longint     cre;
    longint     cim;
    longint     re;
    longint     im;
    longint     rr;
    longint     ii;
    longint     ri;
    longint     k;
    logic       escaped;
    pixel_rec_t rec;
    w   = (frame_width > MAX_DIM) ? MAX_DIM : longint'(frame_width);
    h   = (frame_height > MAX_DIM) ? MAX_DIM : longint'(frame_height);
    mit = longint'(iter_limit);
    rec.oor   = (longint'(col) >= w) || (longint'(row) >= h);
    rec.shade = '0;
    if (!rec.oor) begin
      one = longint'(1) << FRAC_BITS;
      cre = -2 * one + ((longint'(col) * 3) << FRAC_BITS) / w;
      cim = -(7 * one) / 4 + ((longint'(row) * 7) << (FRAC_BITS - 1)) / h;
      re  = cre;
      im  = cim;
      k   = 0;
      escaped = 1'b0;
      while (!escaped && k < mit) begin
        rr = fixed_mul(re, re);
        ii = fixed_mul(im, im);
        ri = fixed_mul(re, im);
        re = rr - ii + cre;
        im = 2 * ri + cim;
        if (fixed_mul(re, re) + fixed_mul(im, im) > 4 * one) escaped = 1'b1;
        else k++;
      end
      if (k < mit) rec.shade = SHADE_W'((k * SHADE_SCALE) / mit);
    end
    rec.addr = ADDR_W'(longint'(row) * w + longint'(col));
    return rec;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_pixels.delete();
      frame_width  = RST_FRAME_WIDTH;
      frame_height = RST_FRAME_HEIGHT;
      iter_limit   = RST_MAX_ITERATIONS;
      pending      = 0;
    end else begin
      // predict with the settings in force before any write at this edge
      if (coord.valid && coord.ready)
        expected_pixels.push_back(shade_pixel(coord.column, coord.row));
      if (pixel.valid && pixel.ready) begin
        got.addr  = pixel.pixel_address;
        got.shade = pixel.shade;
        got.oor   = pixel.out_of_range;
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("pixel beat with nothing expected: addr %0d shade %0d out_of_range %0b",
                     got.addr, got.shade, got.oor);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.addr !== got.addr || want.shade !== got.shade || want.oor !== got.oor) begin
            if (fail_count < 10)
              $display({"pixel beat mismatch (expected/actual): addr %0d/%0d ",
                        "shade %0d/%0d out_of_range %0b/%0b"},
                       want.addr, got.addr, want.shade, got.shade, want.oor, got.oor);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FRAME_WIDTH:    frame_width  = cfg.data[DIM_W-1:0];
          CFG_FRAME_HEIGHT:   frame_height = cfg.data[DIM_W-1:0];
          CFG_MAX_ITERATIONS: iter_limit   = cfg.data[MIT_W-1:0];
          default: ;
        endcase
      end
      pending = expected_pixels.size();
    end
  end

endmodule

FILE: bench/tb.sv
// Top of the escape pixel unit bench: clock, reset, coordinate and config
// stimulus, result back-pressure and the verdict. Checking is in mep_escape_checker.
// Depends on mep_pkg, the three mep_*_if interfaces and the unit itself.
module tb import mep_pkg::*; ();

  localparam int RUN_LIMIT   = 2_500_000;
  localparam int DRAIN_TAIL  = 300;
  localparam int HOLD_CYCLES = 1000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 64;

  // register index past the last register; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int PH_SATURATED = 0;
  localparam int PH_EMPTY     = 1;
  localparam int PH_UNIT      = 2;
  localparam int PH_NO_ITER   = 3;
  localparam int PH_DEEP      = 7;

  logic clk;
  logic rst;

  mep_cfg_if   cfg_ch ();
  mep_coord_if coord_ch ();
  mep_pixel_if pixel_ch ();

  int fail_count;
  int pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_requests;
  int holds_served;
  int cycle_count;
  int frame_cols;
  int frame_rows;

  mandelbrot_escape_pixel_unit u_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .coord (coord_ch),
    .pixel (pixel_ch)
  );

  mep_escape_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .coord      (coord_ch),
    .pixel      (pixel_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int held;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        pixel_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end else begin
        pixel_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_coord(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    while ($urandom_range(99) < snd_idle_pct) begin
      coord_ch.valid <= 1'b0;
      @(negedge clk);
    end
    coord_ch.valid  <= 1'b1;
    coord_ch.column <= col;
    coord_ch.row    <= row;
    @(posedge clk);
    while (!coord_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // leave valid high; the caller drops it after the last write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic [15:0] mit);
    cfg_write(CFG_UNUSED, 16'($urandom));
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    cfg_write(CFG_MAX_ITERATIONS, mit);
    cfg_ch.valid <= 1'b0;
    frame_cols = (w[DIM_W-1:0] > 4096) ? 4096 : int'(w[DIM_W-1:0]);
    frame_rows = (h[DIM_W-1:0] > 4096) ? 4096 : int'(h[DIM_W-1:0]);
  endtask

  // wait for every outstanding pixel beat; never returns in the same cycle it is called
  task automatic drain_pixels();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly inside the frame, sometimes anywhere on the 12-bit axis
  function automatic logic [11:0] pick_position(int extent);
    if (extent > 0 && $urandom_range(99) < 80) return 12'($urandom_range(extent - 1, 0));
    return 12'($urandom_range(4095, 0));
  endfunction

  function automatic logic [15:0] random_dim();
    logic [12:0] dim;
    dim = ($urandom_range(99) < 30) ? 13'($urandom_range(16, 1))
                                    : 13'($urandom_range(4096, 1));
    return {3'($urandom), dim};
  endfunction

  initial begin : stimulus
    logic [15:0] w_val;
    logic [15:0] h_val;
    logic [15:0] mit_val;
    int          p;
    int          i;
    rst             = 1'b1;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_FRAME_WIDTH;
    cfg_ch.data     = '0;
    coord_ch.valid  = 1'b0;
    coord_ch.column = '0;
    coord_ch.row    = '0;
    pixel_ch.ready  = 1'b0;
    snd_idle_pct    = 32;
    rcv_idle_pct    = 45;
    hold_requests   = 0;
    frame_cols      = RST_FRAME_WIDTH;
    frame_rows      = RST_FRAME_HEIGHT;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset frame 640 x 480, 255 iterations
    send_coord(12'd0, 12'd0);        // corner, escapes on the first check
    send_coord(12'd639, 12'd479);    // far corner
    send_coord(12'd320, 12'd240);    // c = -0.5, never escapes
    send_coord(12'd0, 12'd240);      // c = -2 exactly, |z|^2 stays at 4
    send_coord(12'd427, 12'd240);    // near the origin
    send_coord(12'd213, 12'd240);    // near -1
    send_coord(12'd500, 12'd100);
    send_coord(12'd100, 12'd350);
    send_coord(12'd640, 12'd0);      // first column past the frame
    send_coord(12'd0, 12'd480);      // first row past the frame
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd4095, 12'd0);
    send_coord(12'd0, 12'd4095);

    for (p = 0; p < PHASES; p++) begin
      coord_ch.valid <= 1'b0;
      drain_pixels();
      if (p == PH_SATURATED) begin
        // upper data bits masked off, then clamped to 4096
        w_val = 16'hffff;
        h_val = 16'h1fff;
        mit_val = 16'd1;
      end else if (p == PH_EMPTY) begin
        w_val = 16'd0;
        h_val = 16'd0;
        mit_val = 16'($urandom);
      end else if (p == PH_UNIT) begin
        w_val = 16'd1;
        h_val = 16'd1;
        mit_val = 16'hffff;
      end else if (p == PH_NO_ITER) begin
        w_val = 16'd4096;
        h_val = 16'd4096;
        mit_val = 16'd0;
      end else if (p == PH_DEEP) begin
        w_val = random_dim();
        h_val = random_dim();
        mit_val = 16'($urandom_range(400, 200));
      end else begin
        w_val = random_dim();
        h_val = random_dim();
        mit_val = 16'($urandom_range(64, 1));
      end
      set_frame(w_val, h_val, mit_val);
      if (p < 4) begin
        snd_idle_pct = 32;
        rcv_idle_pct = 45;
      end else if (p < 8) begin
        snd_idle_pct = 45;
        rcv_idle_pct = 32;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // stall the result side while short pixels keep arriving
      if (p == PH_SATURATED) hold_requests++;
      for (i = 0; i < PHASE_BEATS; i++)
        send_coord(pick_position(frame_cols), pick_position(frame_rows));
    end
    coord_ch.valid <= 1'b0;
    drain_pixels();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mep_pkg.sv
rtl/mep_cfg_if.sv
rtl/mep_coord_if.sv
rtl/mep_pixel_if.sv
rtl/mandelbrot_escape_pixel_unit.sv
bench/mep_escape_checker.sv
bench/tb.sv
